FILE: src/pba_pkg.sv
// shared constants and types for the pixel binning average block
package pba_pkg;

   // pixel and configuration field widths
   localparam int PIX_W     = 16;
   localparam int CFG_BIN_W = 4;
   localparam int CFG_DIM_W = 13;
   localparam int CSR_IDX_W = 2;

   // default sizing of the line store and the averaging square
   localparam int MAX_WIDTH_DEF = 4096;
   localparam int MAX_BIN_DEF   = 8;
   localparam int HEIGHT_LIMIT  = 4096;

   // register values after reset
   localparam int BIN_RESET    = 2;
   localparam int WIDTH_RESET  = 4096;
   localparam int HEIGHT_RESET = 4096;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIN_FACTOR   = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

endpackage

FILE: src/pba_ram.sv
// generic single write port, single read port ram with registered read data
module pba_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pixel_binning_average_core.sv
// pixel binning average core: box average of each bin x bin square of a pixel raster
//
// usage:
//   req_ channel: one 16-bit pixel per transfer, frame in row order
//   rsp_ channel: one averaged pixel per finished square, with row_end on the
//     last pixel of an output row and frame_end on the last pixel of the frame
//   csr_ channel: index 0 bin factor, 1 image width, 2 image height; always
//     ready; a write takes effect at once and restarts the frame; write only
//     while the block is idle
// latency: a result is valid two cycles after the edge that accepts the pixel
//   that completes its square (accept, line store read and add, scale by the
//   reciprocal of bin squared into the output register)
// throughput: one pixel per cycle; each row of a square after the first reads the
//   line store once per square, each row but the last writes it back, one port each way
// a bin factor of 0 or 1 passes every pixel through with the same latency
// stall: while rsp_ready is low, up to three items wait in the two internal
//   stages and the output register, then req_ready drops
// reset: configuration returns to bin 2, 4096 x 4096 and the frame restarts;
//   the line store needs no clearing pass since each square's first row
//   writes an entry before any later row reads it
module pixel_binning_average_core #(
   parameter int MAX_WIDTH = pba_pkg::MAX_WIDTH_DEF,
   parameter int MAX_BIN   = pba_pkg::MAX_BIN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pba_pkg::PIX_W-1:0]     req_pixel_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pba_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic                          rsp_row_end,
   output logic                          rsp_frame_end,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pba_pkg::CFG_DIM_W-1:0] csr_data
);
   import pba_pkg::*;

   localparam int BIN_W      = $clog2(MAX_BIN + 1);
   localparam int PH_W       = $clog2(MAX_BIN);
   localparam int SQ_W       = $clog2(MAX_BIN * MAX_BIN);
   localparam int HS_W       = PIX_W + $clog2(MAX_BIN);
   localparam int SUM_W      = PIX_W + SQ_W;
   localparam int SHIFT      = SUM_W + SQ_W;
   localparam int RW         = SHIFT - 1;
   localparam int PROD_W     = SUM_W + RW;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int LA_W       = $clog2(LINE_DEPTH);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int DIM_W      = (CFG_DIM_W > COL_W + 1) ? CFG_DIM_W : COL_W + 1;
   localparam int CMP_W      = DIM_W + 1;
   localparam int ROW_W      = $clog2(HEIGHT_LIMIT);
   localparam int RCMP_W     = CFG_DIM_W + 1;

   // configuration registers
   logic [CFG_BIN_W-1:0] bin_ff, bin_in;
   logic [CFG_DIM_W-1:0] width_ff, width_in;
   logic [CFG_DIM_W-1:0] height_ff, height_in;

   // raster position state
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] cbase_ff, cbase_in;
   logic [PH_W-1:0]  cph_ff, cph_in;
   logic [LA_W-1:0]  grp_ff, grp_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W-1:0] rbase_ff, rbase_in;
   logic [PH_W-1:0]  rph_ff, rph_in;
   logic [HS_W-1:0]  hsum_ff, hsum_in;

   // stage 1: line store data arrives
   logic             s1_v_ff, s1_v_in;
   logic             s1_load;
   logic [SUM_W-1:0] s1_sum_ff, s1_sum_in;
   logic             s1_use_ram_ff, s1_use_ram_in;
   logic             s1_is_out_ff, s1_is_out_in;
   logic             s1_pass_ff, s1_pass_in;
   logic             s1_re_ff, s1_re_in;
   logic             s1_fe_ff, s1_fe_in;
   logic [LA_W-1:0]  s1_addr_ff;

   // stage 2: square sum ready for scaling
   logic             s2_v_ff, s2_v_in;
   logic [SUM_W-1:0] s2_acc_ff;
   logic             s2_pass_ff;
   logic             s2_re_ff;
   logic             s2_fe_ff;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic             rsp_row_end_ff;
   logic             rsp_frame_end_ff;

   // decoded configuration and position flags
   logic [BIN_W-1:0]     b_eff, b_m1;
   logic                 pass_mode;
   logic [DIM_W-1:0]     w_eff;
   logic [CFG_DIM_W-1:0] h_eff;
   logic                 col_last, row_last;
   logic                 col_whole, col_last_grp, row_whole, row_last_grp;
   logic                 cph_end, rph_end, rph_zero;
   logic                 accept, cfg_write;
   logic                 out_free, adv2;
   logic [HS_W-1:0]      hsum_sum;

   // line store and scaling
   logic              ram_we, ram_re;
   logic [SUM_W-1:0]  ram_rdata;
   logic [SUM_W-1:0]  s1_acc;
   logic [RW-1:0]     recip_tab [MAX_BIN+1];
   logic [PROD_W-1:0] prod;

   // reciprocal of bin squared, rounded up, one entry per bin factor
   assign recip_tab[0] = '0;
   assign recip_tab[1] = '0;
   for (genvar gi = 2; gi <= MAX_BIN; gi++) begin : g_recip
      localparam longint unsigned SQ    = longint'(gi * gi);
      localparam longint unsigned RECIP = ((64'd1 << SHIFT) + SQ - 64'd1) / SQ;
      assign recip_tab[gi] = RW'(RECIP);
   end

   // effective configuration after clamping
   always_comb begin
      if ({1'b0, bin_ff} > (CFG_BIN_W + 1)'(MAX_BIN)) begin
         b_eff = BIN_W'(MAX_BIN);
      end else begin
         b_eff = BIN_W'(bin_ff);
      end
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (DIM_W'(width_ff) > DIM_W'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = DIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = CFG_DIM_W'(1);
      end else if (height_ff > CFG_DIM_W'(HEIGHT_LIMIT)) begin
         h_eff = CFG_DIM_W'(HEIGHT_LIMIT);
      end else begin
         h_eff = height_ff;
      end
   end

   assign b_m1      = b_eff - BIN_W'(1);
   assign pass_mode = b_eff < BIN_W'(2);

   // position flags for the pixel on the input port
   assign col_last     = DIM_W'(col_ff) >= (w_eff - DIM_W'(1));
   assign row_last     = CFG_DIM_W'(row_ff) >= (h_eff - CFG_DIM_W'(1));
   assign col_whole    = (CMP_W'(cbase_ff) + CMP_W'(b_eff)) <= CMP_W'(w_eff);
   assign col_last_grp = (CMP_W'(cbase_ff) + (CMP_W'(b_eff) << 1)) > CMP_W'(w_eff);
   assign row_whole    = (RCMP_W'(rbase_ff) + RCMP_W'(b_eff)) <= RCMP_W'(h_eff);
   assign row_last_grp = (RCMP_W'(rbase_ff) + (RCMP_W'(b_eff) << 1)) > RCMP_W'(h_eff);
   assign cph_end      = BIN_W'(cph_ff) == b_m1;
   assign rph_end      = BIN_W'(rph_ff) == b_m1;
   assign rph_zero     = rph_ff == '0;
   assign hsum_sum     = hsum_ff + HS_W'(req_pixel_in);

   // pipeline flow control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign adv2      = !s2_v_ff || out_free;
   assign req_ready = !s1_v_ff || adv2;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign cfg_write = csr_valid && csr_ready;

   // next state of configuration, position and stage 1 load
   always_comb begin
      bin_in        = bin_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      col_in        = col_ff;
      cbase_in      = cbase_ff;
      cph_in        = cph_ff;
      grp_in        = grp_ff;
      row_in        = row_ff;
      rbase_in      = rbase_ff;
      rph_in        = rph_ff;
      hsum_in       = hsum_ff;
      s1_load       = 1'b0;
      s1_sum_in     = SUM_W'(hsum_sum);
      s1_use_ram_in = !rph_zero;
      s1_is_out_in  = rph_end;
      s1_pass_in    = 1'b0;
      s1_re_in      = col_last_grp;
      s1_fe_in      = col_last_grp && row_last_grp;
      ram_re        = 1'b0;

      if (cfg_write) begin
         case (csr_index)
            CSR_BIN_FACTOR:   bin_in    = csr_data[CFG_BIN_W-1:0];
            CSR_IMAGE_WIDTH:  width_in  = csr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
         if (csr_index inside {CSR_BIN_FACTOR, CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT}) begin
            col_in   = '0;
            cbase_in = '0;
            cph_in   = '0;
            grp_in   = '0;
            row_in   = '0;
            rbase_in = '0;
            rph_in   = '0;
            hsum_in  = '0;
         end
      end else if (accept) begin
         // work on the pixel itself
         if (pass_mode) begin
            s1_load       = 1'b1;
            s1_sum_in     = SUM_W'(req_pixel_in);
            s1_use_ram_in = 1'b0;
            s1_is_out_in  = 1'b1;
            s1_pass_in    = 1'b1;
            s1_re_in      = col_last;
            s1_fe_in      = col_last && row_last;
         end else if (col_whole && row_whole) begin
            if (cph_end) begin
               s1_load = 1'b1;
               ram_re  = !rph_zero;
               hsum_in = '0;
            end else begin
               hsum_in = hsum_sum;
            end
         end

         // advance the raster position
         if (col_last) begin
            col_in   = '0;
            cbase_in = '0;
            cph_in   = '0;
            grp_in   = '0;
            hsum_in  = '0;
            if (row_last) begin
               row_in   = '0;
               rbase_in = '0;
               rph_in   = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
               if (rph_end) begin
                  rph_in   = '0;
                  rbase_in = row_ff + ROW_W'(1);
               end else begin
                  rph_in = rph_ff + PH_W'(1);
               end
            end
         end else begin
            col_in = col_ff + COL_W'(1);
            if (cph_end) begin
               cph_in   = '0;
               cbase_in = col_ff + COL_W'(1);
               grp_in   = grp_ff + LA_W'(1);
            end else begin
               cph_in = cph_ff + PH_W'(1);
            end
         end
      end
   end

   // stage 1 combines the row sum with the partial square sum
   assign s1_acc = s1_sum_ff + (s1_use_ram_ff ? ram_rdata : '0);
   assign ram_we = s1_v_ff && adv2 && !s1_is_out_ff;

   // stage valids and output valid
   always_comb begin
      if (s1_load) begin
         s1_v_in = 1'b1;
      end else if (adv2) begin
         s1_v_in = 1'b0;
      end else begin
         s1_v_in = s1_v_ff;
      end
      if (adv2) begin
         s2_v_in = s1_v_ff && s1_is_out_ff;
      end else begin
         s2_v_in = s2_v_ff;
      end
      if (out_free) begin
         rsp_valid_in = s2_v_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // scale by the reciprocal of bin squared
   assign prod = PROD_W'(s2_acc_ff) * PROD_W'(recip_tab[b_eff]);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff       <= CFG_BIN_W'(BIN_RESET);
         width_ff     <= CFG_DIM_W'(WIDTH_RESET);
         height_ff    <= CFG_DIM_W'(HEIGHT_RESET);
         col_ff       <= '0;
         cbase_ff     <= '0;
         cph_ff       <= '0;
         grp_ff       <= '0;
         row_ff       <= '0;
         rbase_ff     <= '0;
         rph_ff       <= '0;
         hsum_ff      <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bin_ff       <= bin_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         cbase_ff     <= cbase_in;
         cph_ff       <= cph_in;
         grp_ff       <= grp_in;
         row_ff       <= row_in;
         rbase_ff     <= rbase_in;
         rph_ff       <= rph_in;
         hsum_ff      <= hsum_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_sum_ff     <= s1_sum_in;
         s1_use_ram_ff <= s1_use_ram_in;
         s1_is_out_ff  <= s1_is_out_in;
         s1_pass_ff    <= s1_pass_in;
         s1_re_ff      <= s1_re_in;
         s1_fe_ff      <= s1_fe_in;
         s1_addr_ff    <= grp_ff;
      end
      if (adv2 && s1_v_ff && s1_is_out_ff) begin
         s2_acc_ff  <= s1_acc;
         s2_pass_ff <= s1_pass_ff;
         s2_re_ff   <= s1_re_ff;
         s2_fe_ff   <= s1_fe_ff;
      end
      if (out_free && s2_v_ff) begin
         rsp_pixel_ff     <= s2_pass_ff ? s2_acc_ff[PIX_W-1:0] : prod[SHIFT+PIX_W-1:SHIFT];
         rsp_row_end_ff   <= s2_re_ff;
         rsp_frame_end_ff <= s2_fe_ff;
      end
   end

   // line store of partial square sums, one entry per output column
   pba_ram #(
      .WIDTH(SUM_W),
      .DEPTH(LINE_DEPTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(s1_addr_ff),
      .wr_data(s1_acc),
      .rd_en  (ram_re),
      .rd_addr(grp_ff),
      .rd_data(ram_rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // a write-back never collides with a read of the same column entry
   assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (s1_addr_ff != grp_ff))
      else $error("line store read and write hit the same entry");

   // the frame end always falls on a row end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_frame_end || rsp_row_end))
      else $error("frame end without row end");

   // a finished square waiting on a stalled output is kept
   assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && !out_free && !cfg_write) |=> s2_v_ff)
      else $error("stage 2 result lost while output stalled");

endmodule
